FILE: rtl/alt_pkg.sv
package alt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int SLOT_LIMIT  = 256;
  localparam int SEARCH_END  = (TABLE_DEPTH < SLOT_LIMIT) ? TABLE_DEPTH : SLOT_LIMIT;
  localparam int ADDR_W      = $clog2(SEARCH_END);
  localparam int FIRST_SLOT  = 2;

  // Field widths
  localparam int MAC_W  = 48;
  localparam int SLOT_W = 8;

  // Command codes
  localparam logic CMD_DISCOVER = 1'b0;
  localparam logic CMD_REQUEST  = 1'b1;

  // Reply codes
  typedef enum logic [1:0] {
    KIND_FULL  = 2'd0,
    KIND_OFFER = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_TAKEN = 2'd3
  } kind_t;

  // One table entry as seen by the compare unit
  typedef struct packed {
    logic             used;
    logic [MAC_W-1:0] mac;
  } entry_t;

endpackage

FILE: rtl/address_lease_table.sv
// address_lease_table: lease table of client hardware addresses.
// Input channel (in_valid/in_ready) carries one message: cmd (discover or
// request), client_mac and requested_slot. Output channel (out_valid/out_ready)
// returns exactly one reply per message: reply_kind and slot.
// A message is handled alone: in_ready is low from acceptance until its reply
// has been moved into the output register. The table is read one entry per
// cycle through the single read port of the address RAM, starting at slot 2,
// and the scan stops at the first empty slot, the client's own lease or the
// last slot of the search range. A request reads the requested slot first and
// is answered as taken, without a scan, when that slot is out of range or is
// leased to another client; a full table costs the whole search range.
// Reset clears all lease valid bits at once (flip-flops), so the block is
// usable on the cycle after reset; the address RAM itself needs no clearing.
// When the receiver stalls, the reply holds in the output register; one more
// message may be accepted and worked on, and its reply waits until the
// register frees.
module address_lease_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           cmd,
  input  logic [alt_pkg::MAC_W-1:0]      client_mac,
  input  logic [alt_pkg::SLOT_W-1:0]     requested_slot,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     reply_kind,
  output logic [alt_pkg::SLOT_W-1:0]     slot
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_REQ_RD  = 5'b00010,
    ST_REQ_CMP = 5'b00100,
    ST_SCAN    = 5'b01000,
    ST_DONE    = 5'b10000
  } state_t;

  localparam logic [alt_pkg::ADDR_W-1:0] LAST_ADDR =
    alt_pkg::ADDR_W'(alt_pkg::SEARCH_END - 1);
  localparam logic [alt_pkg::ADDR_W-1:0] START_ADDR =
    alt_pkg::ADDR_W'(alt_pkg::FIRST_SLOT);

  state_t                        state;
  logic                          cur_cmd;
  logic [alt_pkg::MAC_W-1:0]     cur_mac;
  logic [alt_pkg::ADDR_W-1:0]    req_addr;
  logic                          req_in_range;
  logic [alt_pkg::ADDR_W-1:0]    scan_ptr;
  logic [alt_pkg::ADDR_W-1:0]    cmp_slot;
  logic                          cmp_vld;
  logic [alt_pkg::SEARCH_END-1:0] lease_valid;
  alt_pkg::kind_t                res_kind;
  logic [alt_pkg::SLOT_W-1:0]    res_slot;
  logic                          do_write;
  logic [alt_pkg::ADDR_W-1:0]    wr_addr;

  logic [alt_pkg::ADDR_W-1:0]    ram_raddr;
  logic [alt_pkg::MAC_W-1:0]     ram_rdata;
  logic                          ram_we;
  logic [alt_pkg::ADDR_W-1:0]    chk_idx;
  alt_pkg::entry_t               chk_entry;
  logic                          hit;
  logic                          out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign ram_we   = (state == ST_DONE) && out_free && do_write;

  // Read address: requested slot first, then the scan pointer
  always_comb begin
    ram_raddr = scan_ptr;
    if (state == ST_REQ_RD) begin
      ram_raddr = req_addr;
    end
  end

  // Shared compare unit input: the entry whose read data is now valid
  always_comb begin
    chk_idx = cmp_slot;
    if (state == ST_REQ_CMP) begin
      chk_idx = req_addr;
    end
    chk_entry.used = lease_valid[chk_idx];
    chk_entry.mac  = ram_rdata;
  end

  alt_ram #(
    .WIDTH (alt_pkg::MAC_W),
    .DEPTH (alt_pkg::SEARCH_END)
  ) u_mac_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (cur_mac),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  alt_match u_match (
    .entry      (chk_entry),
    .client_mac (cur_mac),
    .hit        (hit)
  );

  // Message latch
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_cmd      <= cmd;
      cur_mac      <= client_mac;
      req_addr     <= requested_slot[alt_pkg::ADDR_W-1:0];
      req_in_range <= ({1'b0, requested_slot} <
                       (alt_pkg::SLOT_W + 1)'(alt_pkg::SEARCH_END));
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cmp_vld <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            scan_ptr <= START_ADDR;
            cmp_vld  <= 1'b0;
            if (cmd == alt_pkg::CMD_REQUEST) begin
              state <= ST_REQ_RD;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_REQ_RD: begin
          state <= ST_REQ_CMP;
        end
        ST_REQ_CMP: begin
          if (req_in_range && hit) begin
            state <= ST_SCAN;
          end else begin
            res_kind <= alt_pkg::KIND_TAKEN;
            res_slot <= '0;
            do_write <= 1'b0;
            state    <= ST_DONE;
          end
        end
        ST_SCAN: begin
          // issue one read per cycle, compare the previous one
          cmp_vld  <= 1'b1;
          cmp_slot <= scan_ptr;
          if (scan_ptr != LAST_ADDR) begin
            scan_ptr <= scan_ptr + 1'b1;
          end
          if (cmp_vld && hit) begin
            res_slot <= alt_pkg::SLOT_W'(cmp_slot);
            wr_addr  <= cmp_slot;
            if (cur_cmd == alt_pkg::CMD_REQUEST) begin
              res_kind <= alt_pkg::KIND_ACK;
              do_write <= 1'b1;
            end else begin
              res_kind <= lease_valid[cmp_slot] ? alt_pkg::KIND_ACK
                                                : alt_pkg::KIND_OFFER;
              do_write <= 1'b0;
            end
            state <= ST_DONE;
          end else if (cmp_vld && (cmp_slot == LAST_ADDR)) begin
            res_kind <= alt_pkg::KIND_FULL;
            res_slot <= '0;
            do_write <= 1'b0;
            state    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Lease valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      lease_valid <= '0;
    end else if (ram_we) begin
      lease_valid[wr_addr] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      reply_kind <= res_kind;
      slot       <= res_slot;
    end
  end

`ifndef SYNTHESIS
  a_write_searched_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (wr_addr >= START_ADDR))
    else $error("lease written below first searchable slot");

  a_empty_reply_slot: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((reply_kind == alt_pkg::KIND_FULL) ||
                   (reply_kind == alt_pkg::KIND_TAKEN))) |-> (slot == '0))
    else $error("full or taken reply carries a slot");

  a_granted_slot_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((reply_kind == alt_pkg::KIND_OFFER) ||
                   (reply_kind == alt_pkg::KIND_ACK))) |->
    (slot >= alt_pkg::SLOT_W'(alt_pkg::FIRST_SLOT)))
    else $error("offer or ack names a reserved slot");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request accepted while one is in work");

  a_reserved_never_valid: assert property (@(posedge clk) disable iff (rst)
    lease_valid[1:0] == 2'b00)
    else $error("reserved slot marked as leased");
`endif

endmodule

FILE: rtl/alt_ram.sv
module alt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/alt_match.sv
module alt_match (
  input  alt_pkg::entry_t               entry,
  input  logic [alt_pkg::MAC_W-1:0]     client_mac,
  output logic                          hit
);

  // Slot is usable when empty or already leased to this client
  assign hit = !entry.used || (entry.mac == client_mac);

endmodule

FILE: bench/tb_address_lease_table.sv
`timescale 1ns / 1ps

module tb_address_lease_table;
  import alt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_ITEMS = 450;
  localparam int unsigned SETTLE_CYCLES = 300;   // room for a full-table scan

  logic              clk;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              cmd = CMD_DISCOVER;
  logic [MAC_W-1:0]  client_mac = '0;
  logic [SLOT_W-1:0] requested_slot = '0;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        reply_kind;
  logic [SLOT_W-1:0] slot;

  bit          steady = 1'b0;   // no idling on either side while set
  int unsigned rx_hold = 0;     // cycles the receiver still has to hold off
  int unsigned cycles = 0;

  typedef struct {
    kind_t             kind;
    bit [SLOT_W-1:0]   slot;
  } lease_reply_t;

  // Mirror of the lease table plus the replies still owed by the block
  class lease_shadow;
    bit               used [TABLE_DEPTH];
    bit [MAC_W-1:0]   owner [TABLE_DEPTH];
    lease_reply_t     pending_replies[$];
    int unsigned      faults;

    // First slot from the bottom of the search range that is free or owned by mac
    function int unsigned search(bit [MAC_W-1:0] mac);
      for (int s = FIRST_SLOT; s < SEARCH_END; s++) begin
        if (!used[s] || owner[s] == mac) return s;
      end
      return 0;
    endfunction

    function int unsigned lease_count();
      int unsigned n;
      n = 0;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
        if (used[s]) n++;
      end
      return n;
    endfunction

    // Address of some current lease holder
    function bit [MAC_W-1:0] some_tenant();
      int unsigned s;
      s = $urandom_range(SEARCH_END - 1);
      repeat (SEARCH_END) begin
        if (used[s]) return owner[s];
        s = (s + 1) % SEARCH_END;
      end
      return '0;
    endfunction

    // Predict the reply to an accepted request and update the table
    function void note_message(bit c, bit [MAC_W-1:0] mac, bit [SLOT_W-1:0] want);
      int unsigned  hit;
      bit           granted;
      lease_reply_t r;
      hit = search(mac);
      r.slot = '0;
      if (c == CMD_DISCOVER) begin
        if (hit == 0) begin
          r.kind = KIND_FULL;
        end else begin
          r.kind = used[hit] ? KIND_ACK : KIND_OFFER;
          r.slot = SLOT_W'(hit);
        end
      end else begin
        granted = 1'b0;
        if (want < TABLE_DEPTH) granted = !used[want] || owner[want] == mac;
        if (!granted) begin
          r.kind = KIND_TAKEN;
        end else if (hit == 0) begin
          r.kind = KIND_FULL;   // nowhere to record the client
        end else begin
          used[hit] = 1'b1;
          owner[hit] = mac;
          r.kind = KIND_ACK;
          r.slot = SLOT_W'(hit);
        end
      end
      pending_replies.push_back(r);
    endfunction

    function void check_reply(logic [1:0] got_kind, logic [SLOT_W-1:0] got_slot);
      lease_reply_t want;
      if (pending_replies.size() == 0) begin
        faults++;
        $display("%0t: unexpected reply kind %0d slot %0d", $time, got_kind, got_slot);
        return;
      end
      want = pending_replies.pop_front();
      if (got_kind !== want.kind) begin
        faults++;
        $display("%0t: reply_kind expected %0d actual %0d", $time, want.kind, got_kind);
      end
      if (got_slot !== want.slot) begin
        faults++;
        $display("%0t: slot expected %0d actual %0d", $time, want.slot, got_slot);
      end
    endfunction
  endclass

  lease_shadow shadow = new;

  address_lease_table DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .client_mac     (client_mac),
    .requested_slot (requested_slot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .reply_kind     (reply_kind),
    .slot           (slot)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Reply checker
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) shadow.check_reply(reply_kind, slot);
  end

  // Receiver: random stalls, plus a long hold-off when asked for
  initial begin
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (rx_hold != 0) begin
        out_ready = 1'b0;
        rx_hold--;
      end else begin
        out_ready = steady || ($urandom_range(99) >= 16);
      end
    end
  end

  // Offer one request; called and returns on a falling edge
  task automatic push_msg(input bit c, input bit [MAC_W-1:0] mac,
                          input bit [SLOT_W-1:0] want);
    in_valid = 1'b1;
    cmd = c;
    client_mac = mac;
    requested_slot = want;
    do @(posedge clk); while (!in_ready);
    shadow.note_message(c, mac, want);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 16) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  initial begin
    bit               c;
    bit [MAC_W-1:0]   m;
    bit [SLOT_W-1:0]  r;
    bit               filling;
    int unsigned      pick;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reserved slots, own lease, one-bit-off address, field extremes
    push_msg(CMD_DISCOVER, 48'h0,              8'h00);  // offer 2
    push_msg(CMD_DISCOVER, 48'hFFFF_FFFF_FFFF, 8'hFF);  // offer 2
    push_msg(CMD_REQUEST,  48'hFFFF_FFFF_FFFF, 8'h00);  // reserved slot passes
    push_msg(CMD_DISCOVER, 48'hFFFF_FFFF_FFFF, 8'h00);  // existing lease -> ack
    push_msg(CMD_REQUEST,  48'h0,              8'h01);  // reserved slot passes
    push_msg(CMD_REQUEST,  48'hFFFF_FFFF_FFFE, 8'h02);  // held by neighbor -> taken
    push_msg(CMD_REQUEST,  48'hFFFF_FFFF_FFFF, 8'h02);  // own slot
    push_msg(CMD_REQUEST,  48'h0,              8'hFF);  // empty slot, found elsewhere
    push_msg(CMD_REQUEST,  48'hFFFF_FFFF_FFFE, 8'h03);  // taken
    push_msg(CMD_REQUEST,  48'hFFFF_FFFF_FFFE, 8'hC8);
    push_msg(CMD_DISCOVER, 48'h8000_0000_0000, 8'h00);
    push_msg(CMD_REQUEST,  48'h5555_5555_5555, 8'hAA);
    push_msg(CMD_REQUEST,  48'hAAAA_AAAA_AAAA, 8'h55);
    push_msg(CMD_DISCOVER, 48'h0000_0000_0001, 8'hFF);
    push_msg(CMD_DISCOVER, 48'h0,              8'h80);
    push_msg(CMD_REQUEST,  48'h0000_0000_0001, 8'h05);  // taken
    push_msg(CMD_REQUEST,  48'h0000_0000_0001, 8'h07);

    // Random: mostly fresh clients claiming slots until the table fills,
    // then a mix of holders, strangers and near-miss addresses on a full table
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 120) rx_hold = 400;
      if (i == 220) begin
        in_valid = 1'b0;
        while (shadow.pending_replies.size() != 0) @(negedge clk);
      end
      steady = (i >= 300 && i < 360);
      filling = shadow.lease_count() < SEARCH_END - FIRST_SLOT;

      pick = $urandom_range(99);
      if (filling) begin
        c = (pick < 92) ? CMD_REQUEST : CMD_DISCOVER;
        if ($urandom_range(99) < 92) m = {16'($urandom), 32'($urandom)};
        else m = shadow.some_tenant();
      end else begin
        c = 1'($urandom_range(1));
        if (pick < 45) m = shadow.some_tenant();
        else if (pick < 55) m = shadow.some_tenant() ^ (48'h1 << $urandom_range(MAC_W - 1));
        else m = {16'($urandom), 32'($urandom)};
      end

      pick = $urandom_range(99);
      if (pick < 15) r = SLOT_W'($urandom_range(1));
      else if (pick < (filling ? 95 : 50)) r = SLOT_W'(shadow.search(m));
      else r = SLOT_W'($urandom_range(255));

      push_msg(c, m, r);
    end
    in_valid = 1'b0;

    while (shadow.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (shadow.faults == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
